>>> src/tgm_pkg.sv
// Shared types, constants and helpers for the two-key gesture menu controller.
`default_nettype none
package tgm_pkg;

	localparam int AGENT_SLOTS = 4;
	localparam int NAV_ENTRIES = 4;
	localparam int CMD_SLOTS   = 8;
	localparam int MAX_EV      = 4;

	// configuration register indexes
	localparam logic [2:0] CFG_DEBOUNCE  = 3'd0;
	localparam logic [2:0] CFG_MIC_HOLD  = 3'd1;
	localparam logic [2:0] CFG_DBL_WIN   = 3'd2;
	localparam logic [2:0] CFG_LONG      = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT   = 3'd4;
	localparam logic [2:0] CFG_AGENTS    = 3'd5;
	localparam logic [2:0] CFG_CUR_AGENT = 3'd6;

	// event codes
	localparam logic [3:0] EV_NONE     = 4'd0;
	localparam logic [3:0] EV_SEND     = 4'd1;
	localparam logic [3:0] EV_ESCAPE   = 4'd2;
	localparam logic [3:0] EV_MIC_DN   = 4'd3;
	localparam logic [3:0] EV_MIC_UP   = 4'd4;
	localparam logic [3:0] EV_AGENT    = 4'd5;
	localparam logic [3:0] EV_NO_AGENT = 4'd6;
	localparam logic [3:0] EV_APPROVE  = 4'd7;
	localparam logic [3:0] EV_DECLINE  = 4'd8;
	localparam logic [3:0] EV_FORK     = 4'd9;
	localparam logic [3:0] EV_FAST     = 4'd10;
	localparam logic [3:0] EV_NAV      = 4'd11;

	// control center slots
	localparam logic [2:0] CC_AGENT    = 3'd0;
	localparam logic [2:0] CC_APPROVE  = 3'd1;
	localparam logic [2:0] CC_DECLINE  = 3'd2;
	localparam logic [2:0] CC_FORK     = 3'd3;
	localparam logic [2:0] CC_FAST     = 3'd4;
	localparam logic [2:0] CC_NAV      = 3'd5;
	localparam logic [2:0] CC_USAGE    = 3'd6;
	localparam logic [2:0] CC_SETTINGS = 3'd7;

	localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

	typedef enum logic [2:0] {
		M_HOME     = 3'd0,
		M_CC       = 3'd1,
		M_AGENT    = 3'd2,
		M_NAV      = 3'd3,
		M_USAGE    = 3'd4,
		M_SETTINGS = 3'd5,
		M_DECLINE  = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPECIAL,
		PH_KEYB,
		PH_KEYA,
		PH_HOLDA,
		PH_HOLDB,
		PH_SEND,
		PH_PUSH
	} phase_t;

	typedef struct packed {
		logic [3:0] code;
		logic [2:0] val;
	} ev_t;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  menu;
		logic [2:0]  sub;
		logic [15:0] rev;
	} view_t;

	// one poll's worth of results
	typedef struct packed {
		ev_t [MAX_EV-1:0] ev;
		logic [2:0]       cnt;
		view_t            view;
	} bundle_t;

	// front state, index 0 key one, index 1 key two
	typedef struct packed {
		logic [1:0]       raw;
		logic [1:0]       stb;
		logic [1:0]       ld;
		logic [1:0]       pc;
		logic [1:0][31:0] rct;
		logic [1:0][31:0] pt;
		mode_t            mode;
		logic [2:0]       menu;
		logic [2:0]       sub;
		logic [15:0]      rev;
		logic [31:0]      od;
		logic [31:0]      sd;
		logic             sp;
		logic             dc;
		logic             mic;
		logic             started;
	} fst_t;

	// wrapping step over n entries
	function automatic logic [2:0] wrap_step(logic [2:0] cur, logic back, logic [3:0] n);
		logic [3:0] x;
		x = back ? ({1'b0, cur} + n - 4'd1) : ({1'b0, cur} + 4'd1);
		if (x >= n)
			x = x - n;
		return x[2:0];
	endfunction

	// wrap-safe time compare
	function automatic logic reached(logic [31:0] t, logic [31:0] dl);
		logic [31:0] d;
		d = t - dl;
		return d < HALF_RANGE;
	endfunction

endpackage
`default_nettype wire

>>> src/tgm_front.sv
// Front part: takes polls, debounces keys and runs the gesture/menu sequencer.
`default_nettype none
module tgm_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            cmd,
	input  wire logic [31:0]     now,
	input  wire logic            key1_level,
	input  wire logic            key2_level,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [15:0]     cfg_data,
	output logic                 q_push,
	input  wire logic            q_ready,
	output tgm_pkg::bundle_t     q_data
);
	import tgm_pkg::*;

	logic [15:0] db_q, mht_q, dcw_q, lpt_q, mto_q;
	logic [3:0]  mask_q;
	logic [1:0]  cur_agent_q;

	phase_t phase_q, phase_d;
	fst_t   st_q, st_d;
	ev_t [MAX_EV-1:0] ev_q, ev_d;
	logic [2:0] cnt_q, cnt_d;

	logic        cmd_s1, k1_s1, k2_s1;
	logic [31:0] now_s1, nowt_s1, nows_s1;
	logic        take;

	function automatic logic assigned(logic [2:0] a, logic [3:0] m);
		return ({1'b0, a} < 4'(AGENT_SLOTS)) && (a < 3'd4) && m[a[1:0]];
	endfunction

	assign in_ready = (phase_q == PH_IDLE) || (phase_q == PH_PUSH && q_ready);
	assign take = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_q <= 16'd25;
			mht_q <= 16'd250;
			dcw_q <= 16'd250;
			lpt_q <= 16'd500;
			mto_q <= 16'd8000;
			mask_q <= 4'd0;
			cur_agent_q <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: db_q <= cfg_data;
				CFG_MIC_HOLD: mht_q <= cfg_data;
				CFG_DBL_WIN: dcw_q <= cfg_data;
				CFG_LONG: lpt_q <= cfg_data;
				CFG_TIMEOUT: mto_q <= cfg_data;
				CFG_AGENTS: mask_q <= cfg_data[3:0] & 4'((1 << AGENT_SLOTS) - 1);
				CFG_CUR_AGENT: begin
					if ({1'b0, cfg_data[1:0]} < 4'(AGENT_SLOTS))
						cur_agent_q <= cfg_data[1:0];
				end
				default: ;
			endcase
		end
	end

	// poll capture, with both deadline sums precomputed
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
			k1_s1 <= key1_level;
			k2_s1 <= key2_level;
			now_s1 <= now;
			nowt_s1 <= now + {16'd0, mto_q};
			nows_s1 <= now + {16'd0, dcw_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			st_q <= '0;
			ev_q <= '0;
			cnt_q <= '0;
		end else begin
			phase_q <= phase_d;
			st_q <= st_d;
			ev_q <= ev_d;
			cnt_q <= cnt_d;
		end
	end

	// sequencer: one step of the poll per cycle, holding in the push step while the queue is full
	always_comb begin
		logic        kk, lvl, chg, used, wl, go, e_en, do_step, step_back, found_ok;
		mode_t       gm;
		logic [3:0]  e_code;
		logic [2:0]  e_val, found, v;
		logic [1:0]  bumps;
		logic [31:0] el;
		logic [3:0]  s;
		logic        ch;

		st_d = st_q;
		ev_d = ev_q;
		cnt_d = cnt_q;
		phase_d = phase_q;
		go = 1'b0;
		gm = M_HOME;
		e_en = 1'b0;
		e_code = EV_NONE;
		e_val = 3'd0;
		do_step = 1'b0;
		step_back = 1'b0;
		bumps = 2'd0;
		kk = 1'b0;
		lvl = 1'b0;
		chg = 1'b0;
		used = 1'b0;
		wl = 1'b0;
		el = '0;
		found = 3'd0;
		found_ok = 1'b0;
		s = '0;
		v = '0;
		ch = 1'b0;
		q_push = 1'b0;
		q_data = '0;

		unique case (phase_q)
			PH_IDLE: ;
			PH_SPECIAL: begin
				if (cmd_s1) begin
					st_d.mic = 1'b0;
					st_d.sp = 1'b0;
					st_d.sd = '0;
					st_d.dc = 1'b0;
					st_d.pc = st_q.stb;
					go = 1'b1;
					gm = M_HOME;
				end else begin
					st_d = '0;
					st_d.raw = {k2_s1, k1_s1};
					st_d.stb = {k2_s1, k1_s1};
					st_d.rct[0] = now_s1;
					st_d.rct[1] = now_s1;
					st_d.pt[0] = now_s1;
					st_d.pt[1] = now_s1;
					st_d.started = 1'b1;
				end
				phase_d = PH_PUSH;
			end
			PH_KEYB, PH_KEYA: begin
				kk = (phase_q == PH_KEYB);
				lvl = kk ? k2_s1 : k1_s1;
				chg = (lvl != st_q.raw[kk]);
				if (chg) begin
					st_d.raw[kk] = lvl;
					st_d.rct[kk] = now_s1;
				end
				el = chg ? 32'd0 : (now_s1 - st_q.rct[kk]);
				if (st_d.stb[kk] != st_d.raw[kk] && el >= {16'd0, db_q}) begin
					st_d.stb[kk] = st_d.raw[kk];
					if (st_d.raw[kk]) begin
						// press
						st_d.pt[kk] = now_s1;
						st_d.ld[kk] = 1'b0;
						st_d.pc[kk] = 1'b0;
						if (st_d.mode != M_HOME)
							st_d.od = nowt_s1;
						if (!kk) begin
							if (st_d.mode == M_HOME) begin
								if (st_d.sp) begin
									st_d.sp = 1'b0;
									st_d.sd = '0;
									st_d.dc = 1'b1;
								end else begin
									st_d.dc = 1'b0;
								end
							end else if (st_d.mode == M_DECLINE) begin
								st_d.pc[0] = 1'b1;
								go = 1'b1;
								gm = M_CC;
							end
						end
					end else begin
						// release
						wl = st_q.ld[kk];
						used = st_q.pc[kk];
						if (!kk) begin
							if (st_d.mic) begin
								st_d.mic = 1'b0;
								st_d.dc = 1'b0;
								e_en = 1'b1;
								e_code = EV_MIC_UP;
							end else if (st_d.mode == M_HOME && !used) begin
								if (st_d.dc) begin
									st_d.dc = 1'b0;
									st_d.sd = '0;
									e_en = 1'b1;
									e_code = EV_ESCAPE;
								end else begin
									st_d.sp = 1'b1;
									st_d.sd = nows_s1;
								end
							end else if (!wl && !used) begin
								do_step = 1'b1;
							end
						end else if (st_d.mode == M_DECLINE) begin
							if (!used) begin
								e_en = 1'b1;
								e_code = EV_DECLINE;
								go = 1'b1;
								gm = M_CC;
							end
						end else if (!wl && !used) begin
							if (st_d.mode == M_HOME) begin
								// next assigned agent after the current one
								for (int off = AGENT_SLOTS; off >= 1; off--) begin
									s = {2'd0, cur_agent_q} + 4'(off);
									if (s >= 4'(AGENT_SLOTS))
										s = s - 4'(AGENT_SLOTS);
									if (assigned(s[2:0], mask_q)) begin
										found_ok = 1'b1;
										found = s[2:0];
									end
								end
								e_en = 1'b1;
								e_code = found_ok ? EV_AGENT : EV_NO_AGENT;
								e_val = found_ok ? found : 3'd0;
							end else if (st_d.mode == M_CC) begin
								case (st_d.menu)
									CC_AGENT: begin
										v = {1'b0, cur_agent_q};
										if (st_d.sub != v) begin
											st_d.sub = v;
											bumps = bumps + 2'd1;
										end
										go = 1'b1;
										gm = M_AGENT;
									end
									CC_APPROVE: begin
										e_en = 1'b1;
										e_code = EV_APPROVE;
										st_d.od = nowt_s1;
									end
									CC_DECLINE: begin
										go = 1'b1;
										gm = M_DECLINE;
									end
									CC_FORK: begin
										e_en = 1'b1;
										e_code = EV_FORK;
										st_d.od = nowt_s1;
									end
									CC_FAST: begin
										e_en = 1'b1;
										e_code = EV_FAST;
										st_d.od = nowt_s1;
									end
									CC_NAV: begin
										if (st_d.sub != 3'd0) begin
											st_d.sub = 3'd0;
											bumps = bumps + 2'd1;
										end
										go = 1'b1;
										gm = M_NAV;
									end
									CC_USAGE: begin
										go = 1'b1;
										gm = M_USAGE;
									end
									default: begin
										go = 1'b1;
										gm = M_SETTINGS;
									end
								endcase
							end else if (st_d.mode == M_AGENT) begin
								e_en = 1'b1;
								e_code = assigned(st_d.sub, mask_q) ? EV_AGENT : EV_NO_AGENT;
								e_val = st_d.sub;
								st_d.od = nowt_s1;
							end else if (st_d.mode == M_NAV) begin
								e_en = 1'b1;
								e_code = EV_NAV;
								e_val = st_d.sub;
								st_d.od = nowt_s1;
							end
						end
					end
				end
				phase_d = kk ? PH_KEYA : PH_HOLDA;
			end
			PH_HOLDA: begin
				el = now_s1 - st_q.pt[0];
				if (st_d.mode == M_HOME && st_d.stb[0] && !st_d.pc[0] && !st_d.mic &&
				    el >= {16'd0, mht_q}) begin
					st_d.sp = 1'b0;
					st_d.sd = '0;
					st_d.dc = 1'b0;
					st_d.mic = 1'b1;
					e_en = 1'b1;
					e_code = EV_MIC_DN;
				end
				if (st_d.stb[0] && !st_d.ld[0] && el >= {16'd0, lpt_q}) begin
					st_d.ld[0] = 1'b1;
					if (!st_d.pc[0] && st_d.mode != M_HOME) begin
						do_step = 1'b1;
						step_back = 1'b1;
					end
				end
				phase_d = PH_HOLDB;
			end
			PH_HOLDB: begin
				el = now_s1 - st_q.pt[1];
				if (st_d.stb[1] && !st_d.ld[1] && el >= {16'd0, lpt_q}) begin
					st_d.ld[1] = 1'b1;
					if (st_d.mode == M_HOME) begin
						st_d.pc[1] = 1'b1;
						go = 1'b1;
						gm = M_CC;
					end else if (st_d.mode != M_DECLINE) begin
						st_d.pc[1] = 1'b1;
						go = 1'b1;
						gm = (st_d.mode == M_CC) ? M_HOME : M_CC;
					end
				end
				phase_d = PH_SEND;
			end
			PH_SEND: begin
				// committed single click
				if (st_d.sp && reached(now_s1, st_d.sd) &&
				    !(st_d.raw[0] && !st_d.stb[0] && reached(st_d.sd, st_d.rct[0]))) begin
					st_d.sp = 1'b0;
					st_d.sd = '0;
					e_en = 1'b1;
					e_code = EV_SEND;
				end
				phase_d = PH_PUSH;
				// overlay timeout follows in the same step; it depends on the mode, od and the poll time
				if (st_d.mode != M_HOME && st_d.od != 32'd0 && reached(now_s1, st_d.od)) begin
					if (st_d.stb[1])
						st_d.pc[1] = 1'b1;
					go = 1'b1;
					gm = M_HOME;
				end
			end
			PH_PUSH: begin
				q_push = 1'b1;
				q_data.ev = ev_q;
				q_data.cnt = cnt_q;
				if (cnt_q == 3'd0) begin
					q_data.ev[0] = '{code: EV_NONE, val: 3'd0};
					q_data.cnt = 3'd1;
				end
				q_data.view = '{mode: st_q.mode, menu: st_q.menu, sub: st_q.sub,
					rev: st_q.rev};
				if (q_ready)
					phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase

		// menu stepping
		if (do_step) begin
			if (st_d.mode == M_CC) begin
				v = wrap_step(st_d.menu, step_back, 4'(CMD_SLOTS));
				if (st_d.menu != v) begin
					st_d.menu = v;
					bumps = bumps + 2'd1;
				end
			end else if (st_d.mode == M_AGENT || st_d.mode == M_NAV) begin
				v = wrap_step(st_d.sub, step_back,
					(st_d.mode == M_AGENT) ? 4'(AGENT_SLOTS) : 4'(NAV_ENTRIES));
				if (st_d.sub != v) begin
					st_d.sub = v;
					bumps = bumps + 2'd1;
				end
			end
			if (st_d.mode != M_HOME)
				st_d.od = nowt_s1;
		end

		// mode change
		if (go) begin
			ch = (st_d.mode != gm);
			st_d.mode = gm;
			if (gm == M_CC && st_d.menu != 3'd0) begin
				st_d.menu = 3'd0;
				ch = 1'b1;
			end
			if (ch)
				bumps = bumps + 2'd1;
			st_d.od = (gm != M_HOME) ? nowt_s1 : 32'd0;
		end
		st_d.rev = st_d.rev + {14'd0, bumps};

		// event capture
		if (e_en && cnt_d < 3'(MAX_EV)) begin
			ev_d[cnt_d[1:0]] = '{code: e_code, val: e_val};
			cnt_d = cnt_d + 3'd1;
		end

		// next poll
		if (take) begin
			ev_d = '0;
			cnt_d = '0;
			phase_d = (cmd || !st_q.started) ? PH_SPECIAL : PH_KEYB;
		end
	end

endmodule
`default_nettype wire

>>> src/tgm_queue.sv
// Two-entry queue of per-poll result bundles between front and back.
`default_nettype none
module tgm_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  push_ready,
	input  wire tgm_pkg::bundle_t push_data,
	output logic                  pop_valid,
	input  wire logic             pop,
	output tgm_pkg::bundle_t      pop_data
);
	import tgm_pkg::*;

	bundle_t mem [2];
	logic    wr_q, rd_q;
	logic [1:0] cnt_q;
	logic    do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

>>> src/tgm_back.sv
// Back part: unpacks a poll's bundle into result beats, one per cycle while out_ready is high.
`default_nettype none
module tgm_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_pop,
	input  wire tgm_pkg::bundle_t q_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [3:0]            event_code,
	output logic [2:0]            event_value,
	output logic [2:0]            view_mode,
	output logic [2:0]            menu_position,
	output logic [2:0]            submenu_position,
	output logic [15:0]           view_revision,
	output logic                  last_of_run
);
	import tgm_pkg::*;

	bundle_t    cur_q;
	logic       have_q;
	logic [1:0] idx_q;
	logic       fire;

	assign last_of_run = ({1'b0, idx_q} == (cur_q.cnt - 3'd1));
	assign out_valid = have_q;
	assign fire = out_valid && out_ready;
	assign q_pop = q_valid && (!have_q || (fire && last_of_run));

	assign event_code = cur_q.ev[idx_q].code;
	assign event_value = cur_q.ev[idx_q].val;
	assign view_mode = cur_q.view.mode;
	assign menu_position = cur_q.view.menu;
	assign submenu_position = cur_q.view.sub;
	assign view_revision = cur_q.view.rev;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
	end

	// beat sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (q_pop) begin
			have_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (fire) begin
			if (last_of_run)
				have_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

>>> src/two_key_gesture_menu_controller.sv
// Flow: an accepted poll runs two key steps, two hold steps, the send/timeout step and the push;
// cancel and first poll run the special step and the push. The front takes a new poll only when
// idle or in the last one's push step, and a full two-bundle queue holds it in that push step. A
// pushed bundle is registered in the queue and then in the back before its first beat is valid;
// the back emits one beat per cycle while out_ready is high, 1 to 4 beats per poll.
// Reset: arst_n clears all gesture and view state, empties the queue, loads register defaults.
`default_nettype none
module two_key_gesture_menu_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [31:0] now,
	input  wire logic        key1_level,
	input  wire logic        key2_level,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       event_code,
	output logic [2:0]       event_value,
	output logic [2:0]       view_mode,
	output logic [2:0]       menu_position,
	output logic [2:0]       submenu_position,
	output logic [15:0]      view_revision,
	output logic             last_of_run
);
	import tgm_pkg::*;

	logic    f_push, f_ready, b_valid, b_pop;
	bundle_t f_data, b_data;

	tgm_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .now, .key1_level, .key2_level,
		.cfg_we, .cfg_index, .cfg_data,
		.q_push(f_push), .q_ready(f_ready), .q_data(f_data)
	);

	tgm_queue u_queue (
		.clk, .arst_n,
		.push(f_push), .push_ready(f_ready), .push_data(f_data),
		.pop_valid(b_valid), .pop(b_pop), .pop_data(b_data)
	);

	tgm_back u_back (
		.clk, .arst_n,
		.q_valid(b_valid), .q_pop(b_pop), .q_data(b_data),
		.out_valid, .out_ready, .event_code, .event_value, .view_mode,
		.menu_position, .submenu_position, .view_revision, .last_of_run
	);

endmodule
`default_nettype wire

>>> src/tgm_checker.sv
// Port-level checker for the gesture menu controller, bound to the top level.
`default_nettype none
module tgm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  event_code,
	input wire logic [2:0]  view_mode,
	input wire logic [15:0] view_revision,
	input wire logic        last_of_run
);
	import tgm_pkg::*;

	// a stalled beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code))
		else $error("result beat dropped or changed while stalled");

	// event codes stay in range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= EV_NAV)
		else $error("event code out of range");

	// a none event is always alone in its run
	a_none_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_NONE |-> last_of_run)
		else $error("none event inside a longer run");

	// within a run the next beat follows at once with the same view
	a_run_view: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=>
			out_valid && view_mode == $past(view_mode) &&
			view_revision == $past(view_revision))
		else $error("view changed within one run");

endmodule

bind two_key_gesture_menu_controller tgm_checker u_tgm_checker (
	.clk, .arst_n, .out_valid, .out_ready, .event_code, .view_mode,
	.view_revision, .last_of_run
);
`default_nettype wire
